/* sv/gcpd_pkg.sv */
// Shared types, codes and reset values for the Gray code pixel decoder.
package gcpd_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int SAMPLE_BITS_DEF   = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int COORD_W    = 13;
    localparam int STATUS_W   = 2;
    localparam int ERR_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLACK_THR   = 3'd0,
        REG_WHITE_THR   = 3'd1,
        REG_COL_BITS    = 3'd2,
        REG_ROW_BITS    = 3'd3,
        REG_COL_OFFSET  = 3'd4,
        REG_ROW_OFFSET  = 3'd5,
        REG_PROJ_WIDTH  = 3'd6,
        REG_PROJ_HEIGHT = 3'd7
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID      = 2'd0,
        ST_SHADOW     = 2'd1,
        ST_RANGE      = 2'd2,
        ST_UNRELIABLE = 2'd3
    } status_t;

    localparam logic [ERR_W-1:0] ERR_NONE  = 4'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 4'd1;
    localparam logic [ERR_W-1:0] ERR_MAX   = 4'd15;

    typedef struct packed {
        logic [7:0]  black_thr;
        logic [7:0]  white_thr;
        logic [3:0]  col_bits;
        logic [3:0]  row_bits;
        logic [11:0] col_offset;
        logic [11:0] row_offset;
        logic [12:0] proj_width;
        logic [12:0] proj_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        black_thr:   8'd40,
        white_thr:   8'd5,
        col_bits:    4'd10,
        row_bits:    4'd10,
        col_offset:  12'd0,
        row_offset:  12'd0,
        proj_width:  13'd1024,
        proj_height: 13'd768
    };

endpackage

/* sv/gcpd_front.sv */
// Front end: takes intensity pairs, tracks the pixel and builds the binary codes.
module gcpd_front #(
    parameter int MAX_CODE_BITS = gcpd_pkg::MAX_CODE_BITS_DEF,
    parameter int SAMPLE_BITS   = gcpd_pkg::SAMPLE_BITS_DEF,
    parameter int WORD_W        = 2 * MAX_CODE_BITS + 1 + gcpd_pkg::ERR_W
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  gcpd_pkg::cfg_t         cfg,
    input  logic                   in_accept,
    input  logic                   first_of_pixel,
    input  logic [SAMPLE_BITS-1:0] sample_a,
    input  logic [SAMPLE_BITS-1:0] sample_b,
    output logic                   push,
    output logic [WORD_W-1:0]      push_data
);
    import gcpd_pkg::*;

    localparam int MCB = MAX_CODE_BITS;
    localparam int BW  = (MCB > 15) ? 5 : 4;
    localparam int PW  = $clog2(2 * MCB + 1);
    localparam int EW  = PW + 2;
    localparam int DW  = SAMPLE_BITS + 1;

    logic [PW-1:0]    pair_reg, pair_next;
    logic             lit_reg, lit_next;
    logic [MCB-1:0]   col_acc_reg, col_acc_next;
    logic [MCB-1:0]   row_acc_reg, row_acc_next;
    logic             prev_reg, prev_next;
    logic [ERR_W-1:0] err_reg, err_next;

    logic signed [DW-1:0] diff, adiff;
    logic [BW-1:0]        cb, rb;
    logic [PW-1:0]        k_full, k, n;
    logic                 is_row, prev_bit, gray, bin, last;
    logic signed [EW-1:0] nk, code;
    logic [ERR_W-1:0]     err_upd;

    function automatic logic [BW-1:0] eff_bits(input logic [3:0] bits);
        logic [BW-1:0] v;
        v = BW'(bits);
        if (v == '0)
            return BW'(1);
        else if (v > BW'(MCB))
            return BW'(MCB);
        return v;
    endfunction

    always_comb
    begin
        diff   = $signed({1'b0, sample_a}) - $signed({1'b0, sample_b});
        adiff  = (diff < 0) ? -diff : diff;
        gray   = sample_a > sample_b;
        cb     = eff_bits(cfg.col_bits);
        rb     = eff_bits(cfg.row_bits);
        k_full = pair_reg - PW'(1);
        is_row = k_full >= PW'(cb);
        k      = is_row ? (k_full - PW'(cb)) : k_full;
        n      = is_row ? PW'(rb) : PW'(cb);
        // row phase restarts the Gray-to-binary chain
        prev_bit = (is_row && (k == '0)) ? 1'b0 : prev_reg;
        bin      = prev_bit ^ gray;

        nk   = $signed(EW'(n)) - $signed(EW'(k));
        code = nk + EW'(1);
        err_upd = err_reg;
        if ((adiff < $signed(DW'(cfg.white_thr))) && ($signed(EW'(err_reg)) < nk))
        begin
            if (code > $signed(EW'(ERR_MAX)))
                err_upd = ERR_MAX;
            else
                err_upd = code[ERR_W-1:0];
        end

        last = is_row && !((k + PW'(1)) < PW'(rb));

        pair_next    = pair_reg;
        lit_next     = lit_reg;
        col_acc_next = col_acc_reg;
        row_acc_next = row_acc_reg;
        prev_next    = prev_reg;
        err_next     = err_reg;
        push         = 1'b0;

        if (in_accept)
        begin
            if (first_of_pixel)
            begin
                lit_next     = diff > $signed(DW'(cfg.black_thr));
                pair_next    = PW'(1);
                col_acc_next = '0;
                row_acc_next = '0;
                prev_next    = 1'b0;
                err_next     = ERR_NONE;
            end
            else if (pair_reg != '0)
            begin
                err_next  = err_upd;
                prev_next = bin;
                if (is_row)
                    row_acc_next = {row_acc_reg[MCB-2:0], bin};
                else
                    col_acc_next = {col_acc_reg[MCB-2:0], bin};
                if (last)
                begin
                    pair_next = '0;
                    push      = 1'b1;
                end
                else
                begin
                    pair_next = pair_reg + PW'(1);
                end
            end
        end

        push_data = {lit_reg, col_acc_next, row_acc_next, err_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg    <= '0;
            lit_reg     <= 1'b0;
            col_acc_reg <= '0;
            row_acc_reg <= '0;
            prev_reg    <= 1'b0;
            err_reg     <= ERR_NONE;
        end
        else
        begin
            pair_reg    <= pair_next;
            lit_reg     <= lit_next;
            col_acc_reg <= col_acc_next;
            row_acc_reg <= row_acc_next;
            prev_reg    <= prev_next;
            err_reg     <= err_next;
        end
    end

endmodule

/* sv/gcpd_queue.sv */
// Two-entry queue between front and back ends.
module gcpd_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] q_data,
    output logic             full
);
    import gcpd_pkg::*;

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg, count_next;

    assign q_valid = count_reg != 2'd0;
    assign full    = count_reg == 2'd2;
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && q_valid))
            count_next = count_reg + 2'd1;
        else if (!push && pop && q_valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && q_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/gcpd_back.sv */
// Back end: offset subtraction, range check, status and the output register.
module gcpd_back #(
    parameter int MAX_CODE_BITS = gcpd_pkg::MAX_CODE_BITS_DEF,
    parameter int WORD_W        = 2 * MAX_CODE_BITS + 1 + gcpd_pkg::ERR_W
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  gcpd_pkg::cfg_t                          cfg,
    input  logic                                    q_valid,
    input  logic [WORD_W-1:0]                       q_data,
    output logic                                    pop,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [gcpd_pkg::COORD_W-1:0]     proj_col,
    output logic signed [gcpd_pkg::COORD_W-1:0]     proj_row,
    output logic [gcpd_pkg::STATUS_W-1:0]           status,
    output logic [gcpd_pkg::ERR_W-1:0]              error_level
);
    import gcpd_pkg::*;

    localparam int MCB = MAX_CODE_BITS;
    localparam int DW  = (MCB + 1 > 14) ? MCB + 1 : 14;

    logic             lit;
    logic [MCB-1:0]   col_acc, row_acc;
    logic [ERR_W-1:0] err_in, err_out;
    logic signed [DW-1:0] xd, yd;
    status_t          st;

    logic                      valid_reg;
    logic signed [COORD_W-1:0] col_reg, col_next;
    logic signed [COORD_W-1:0] row_reg, row_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic [ERR_W-1:0]          err_reg, err_next;

    assign {lit, col_acc, row_acc, err_in} = q_data;
    assign pop = q_valid && (!valid_reg || !out_stall);

    always_comb
    begin
        xd = $signed(DW'(col_acc)) - $signed(DW'(cfg.col_offset));
        yd = $signed(DW'(row_acc)) - $signed(DW'(cfg.row_offset));
        err_out = err_in;
        if ((err_in == ERR_NONE) &&
            ((yd > $signed(DW'(cfg.proj_height))) || (xd > $signed(DW'(cfg.proj_width)))))
            err_out = ERR_RANGE;
        if (err_out == ERR_NONE)
            st = ST_VALID;
        else if (err_out == ERR_RANGE)
            st = ST_RANGE;
        else
            st = ST_UNRELIABLE;

        if (lit)
        begin
            col_next    = xd[COORD_W-1:0];
            row_next    = yd[COORD_W-1:0];
            status_next = st;
            err_next    = err_out;
        end
        else
        begin
            col_next    = '0;
            row_next    = '0;
            status_next = ST_SHADOW;
            err_next    = ERR_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            status_reg <= status_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    assign out_valid   = valid_reg;
    assign proj_col    = col_reg;
    assign proj_row    = row_reg;
    assign status      = status_reg;
    assign error_level = err_reg;

endmodule

/* sv/gray_code_pattern_pixel_decoder.sv */
// Top level of the structured-light Gray code pixel decoder.
//
// Input channel (in_valid / in_stall) moves one word per pixel pair:
// first_of_pixel marks the white/black reference pair, then come the
// column pairs and the row pairs, MSB first. While in_stall is low, one
// word is accepted per cycle; the front end needs only a subtract, a
// compare and an XOR per pair, so the sustained rate is one pair per
// clock. The last row pair of a pixel produces one result word on the
// output channel (out_valid / out_stall). After that pair is accepted,
// the front end writes the finished codes into the queue, and the back
// end's offset subtract and range compare then load the output register,
// which raises out_valid.
// When the receiver stalls, the output register holds its word and the
// two-entry queue absorbs finished pixels; in_stall rises only once the
// queue is full, so pairs that finish no pixel keep flowing until then.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no result is pending.
// Reset (rst_n low, asynchronous): registers take their default values,
// no pixel is in progress, queue and output register are empty.
module gray_code_pattern_pixel_decoder #(
    parameter int MAX_CODE_BITS = gcpd_pkg::MAX_CODE_BITS_DEF,
    parameter int SAMPLE_BITS   = gcpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // pair input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 first_of_pixel,
    input  logic [SAMPLE_BITS-1:0]               sample_a,
    input  logic [SAMPLE_BITS-1:0]               sample_b,
    // result output
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [gcpd_pkg::COORD_W-1:0]  proj_col,
    output logic signed [gcpd_pkg::COORD_W-1:0]  proj_row,
    output logic [gcpd_pkg::STATUS_W-1:0]        status,
    output logic [gcpd_pkg::ERR_W-1:0]           error_level,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gcpd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gcpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gcpd_pkg::*;

    // queue word: lit flag, column code, row code, error code
    localparam int WORD_W = 2 * MAX_CODE_BITS + 1 + ERR_W;

    cfg_t              cfg_reg;
    logic              in_accept;
    logic              push, pop, q_valid, q_full;
    logic [WORD_W-1:0] push_data, q_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    // register file, written by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_BLACK_THR:   cfg_reg.black_thr   <= cfg_data[7:0];
                REG_WHITE_THR:   cfg_reg.white_thr   <= cfg_data[7:0];
                REG_COL_BITS:    cfg_reg.col_bits    <= cfg_data[3:0];
                REG_ROW_BITS:    cfg_reg.row_bits    <= cfg_data[3:0];
                REG_COL_OFFSET:  cfg_reg.col_offset  <= cfg_data[11:0];
                REG_ROW_OFFSET:  cfg_reg.row_offset  <= cfg_data[11:0];
                REG_PROJ_WIDTH:  cfg_reg.proj_width  <= cfg_data[12:0];
                REG_PROJ_HEIGHT: cfg_reg.proj_height <= cfg_data[12:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    gcpd_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .WORD_W        (WORD_W)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_accept      (in_accept),
        .first_of_pixel (first_of_pixel),
        .sample_a       (sample_a),
        .sample_b       (sample_b),
        .push           (push),
        .push_data      (push_data)
    );

    gcpd_queue #(
        .WIDTH (WORD_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .full      (q_full)
    );

    gcpd_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .WORD_W        (WORD_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .proj_col    (proj_col),
        .proj_row    (proj_row),
        .status      (status),
        .error_level (error_level)
    );

endmodule
